// File: hw/rtl/iir_third_order_filter_unit_macros.svh
// assertion macros for the third-order iir filter checker
`ifndef IIR_THIRD_ORDER_FILTER_UNIT_MACROS_SVH
`define IIR_THIRD_ORDER_FILTER_UNIT_MACROS_SVH

// checked only outside reset
`define IIRTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IIRTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/iirtf_pkg.sv
// shared types, constants and the scaled product for the third-order iir filter
package iirtf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 24;
  localparam int SAMPLE_W  = 32;
  localparam int NUM_COEFS = 7;
  localparam int TAPS      = 3;
  localparam int CFG_IDX_W = 3;

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int CELL_W = TERM_W + 1;
  // head term plus two terms from each of the three cells
  localparam int SUM_W  = TERM_W + 3;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [CELL_W-1:0]   cell_term_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3
  } reg_idx_t;

  localparam coef_t COEF_RESET [NUM_COEFS] = '{
    24'sd4863, -24'sd4024, -24'sd4830, 24'sd4063,
    24'sd179883, -24'sd164948, 24'sd50528
  };

  // one delay-line position: past input and past output
  typedef struct packed {
    sample_t x;
    sample_t y;
  } tap_t;

  typedef struct packed {
    coef_t b;
    coef_t a;
  } tap_coef_t;

  typedef struct packed {
    sample_t sample;
    logic    sat;
  } result_t;

  // full product, then floor shift by the fraction bits
  function automatic term_t scale(input coef_t c, input sample_t s);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(c) * PROD_W'(s);
    return p[PROD_W-1:FRAC_BITS];
  endfunction

endpackage

// File: hw/rtl/iirtf_cell.sv
// one tap of the delay chain: holds a past input and a past output and forms their terms
module iirtf_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift_en,
  input  iirtf_pkg::tap_coef_t   coef,
  input  iirtf_pkg::tap_t        tap_in,
  output iirtf_pkg::tap_t        tap_q,
  output iirtf_pkg::cell_term_t  term
);
  import iirtf_pkg::*;

  tap_t  tap;
  term_t term_x;
  term_t term_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (shift_en) begin
      tap <= tap_in;
    end
  end

  always_comb begin
    term_x = scale(coef.b, tap.x);
    term_y = scale(coef.a, tap.y);
    term   = CELL_W'(term_x) + CELL_W'(term_y);
  end

  assign tap_q = tap;

endmodule

// File: hw/rtl/iirtf_out_buf.sv
// two-entry output buffer: result register plus a skid slot
module iirtf_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  iirtf_pkg::result_t  push_data,
  output logic                push_ready,
  input  logic                pop_ready,
  output logic                out_valid,
  output iirtf_pkg::result_t  out_data
);
  import iirtf_pkg::*;

  result_t head;
  result_t skid;
  logic    head_valid;
  logic    skid_valid;
  logic    pop;

  assign pop = head_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push && (pop || !head_valid)) begin
        head       <= push_data;
        head_valid <= 1'b1;
      end else if (push) begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end else if (pop && skid_valid) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  assign push_ready = ~skid_valid;
  assign out_valid  = head_valid;
  assign out_data   = head;

endmodule

// File: hw/rtl/iir_third_order_filter_unit.sv
// Third-order direct-form-I IIR filter, fixed point with FRAC_BITS fraction bits. One sample
// is taken per cycle while in_ready is high; its result is registered into the output buffer
// on acceptance, and the two-entry buffer lets one more request in while a result waits. The
// rate is set by the feedback loop: the newest output goes through its coefficient multiplier,
// the seven-term adder and the saturation combinationally. The three delay taps are a chain of
// cells that shift on every accepted request. The user must write the seven coefficients through
// the configuration port only while the filter is idle; the block does not enforce it. Writes
// to an index past the last coefficient are dropped. No clearing pass is needed after reset.
module iir_third_order_filter_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  iirtf_pkg::sample_t   sample_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output iirtf_pkg::sample_t   sample_out,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  iirtf_pkg::cfg_idx_t  cfg_index,
  input  iirtf_pkg::coef_t     cfg_data
);
  import iirtf_pkg::*;

  coef_t      coefs [NUM_COEFS];
  tap_coef_t  cell_coef [TAPS];
  tap_t       chain [TAPS+1];
  cell_term_t terms [TAPS];
  term_t      head_term;
  sum_t       sum;
  logic [SUM_W-SAMPLE_W:0] sum_hi;
  sample_t    y_new;
  logic       clip;
  logic       accept;
  result_t    result;
  result_t    out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coefs[i] <= COEF_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && (int'(cfg_index) < NUM_COEFS)) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  assign cell_coef[0] = '{b: coefs[REG_B1], a: coefs[REG_A1]};
  assign cell_coef[1] = '{b: coefs[REG_B2], a: coefs[REG_A2]};
  assign cell_coef[2] = '{b: coefs[REG_B3], a: coefs[REG_A3]};

  assign accept   = in_valid & in_ready;
  assign chain[0] = '{x: sample_in, y: y_new};

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    iirtf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (accept),
      .coef     (cell_coef[k]),
      .tap_in   (chain[k]),
      .tap_q    (chain[k+1]),
      .term     (terms[k])
    );
  end

  always_comb begin
    head_term = scale(coefs[REG_B0], sample_in);
    sum       = SUM_W'(head_term);
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(terms[k]);
    end
    // in range when every bit above the output sign bit matches it
    sum_hi = sum[SUM_W-1:SAMPLE_W-1];
    clip   = ~((&sum_hi) | ~(|sum_hi));
    if (!clip) begin
      y_new = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    result = '{sample: y_new, sat: clip};
  end

  iirtf_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (in_ready),
    .pop_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  assign sample_out = out_data.sample;
  assign saturated  = out_data.sat;

endmodule

// File: hw/rtl/iirtf_checker.sv
// port-level checks for the third-order iir filter, bound to the top level
`include "iir_third_order_filter_unit_macros.svh"

module iirtf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input iirtf_pkg::sample_t   sample_out,
  input logic                 saturated
);
  import iirtf_pkg::*;

  localparam sample_t OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // a stalled result holds
  `IIRTF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated), "stalled result changed")
  // a clipped result sits on a rail
  `IIRTF_ASSERT(a_sat_rail, out_valid && saturated |-> sample_out == OUT_MAX || sample_out == OUT_MIN, "saturated flag without rail value")
  // input can only back up behind a waiting result
  `IIRTF_ASSERT(a_ready_full, !in_ready |-> out_valid, "input stalled with no result pending")
  // reset empties the output
  `IIRTF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && in_ready, "output not empty after reset")

endmodule

bind iir_third_order_filter_unit iirtf_checker u_iirtf_checker (.*);

// File: verif/tb_iir_third_order_filter_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the third-order iir filter unit with an in-bench filter predictor
module tb_iir_third_order_filter_unit;
  import iirtf_pkg::*;

  localparam int       CYCLE_LIMIT   = 200000;
  localparam int       REPORT_LIMIT  = 20;
  localparam int       GAP_CAP       = 40;
  localparam int       DRAIN_CYCLES  = 3;
  localparam cfg_idx_t IDX_PAST_LAST = cfg_idx_t'(NUM_COEFS);
  localparam longint   OUT_HI        = 64'sd2147483647;
  localparam longint   OUT_LO        = -64'sd2147483648;
  localparam coef_t    COEF_MAX      = 24'sh7FFFFF;
  localparam coef_t    COEF_MIN      = 24'sh800000;
  localparam sample_t  SAMPLE_MAX    = 32'sh7FFFFFFF;
  localparam sample_t  SAMPLE_MIN    = 32'sh80000000;
  localparam sample_t  ONE           = sample_t'(1 << FRAC_BITS);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  sample_t  sample_in;
  logic     out_valid;
  logic     out_ready;
  sample_t  sample_out;
  logic     saturated;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  coef_t    cfg_data;

  // predictor state
  coef_t   coef_model [NUM_COEFS];
  sample_t x_hist [TAPS];
  sample_t y_hist [TAPS];
  result_t pending_results [$];
  result_t want;

  int send_pct = 0;
  int recv_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int clipped_seen = 0;
  int coef_writes = 0;
  int random_count = 0;

  iir_third_order_filter_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .saturated  (saturated),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // floor shift of the full product, as the fixed-point format requires
  function automatic longint scaled_term(input coef_t c, input sample_t s);
    return (longint'(c) * longint'(s)) >>> FRAC_BITS;
  endfunction

  function automatic result_t filter_step(input sample_t x);
    longint  acc;
    result_t r;
    acc = scaled_term(coef_model[REG_B0], x)
        + scaled_term(coef_model[REG_B1], x_hist[0])
        + scaled_term(coef_model[REG_B2], x_hist[1])
        + scaled_term(coef_model[REG_B3], x_hist[2])
        + scaled_term(coef_model[REG_A1], y_hist[0])
        + scaled_term(coef_model[REG_A2], y_hist[1])
        + scaled_term(coef_model[REG_A3], y_hist[2]);
    r.sat = 1'b0;
    if (acc > OUT_HI) begin
      r.sample = SAMPLE_MAX;
      r.sat = 1'b1;
    end else if (acc < OUT_LO) begin
      r.sample = SAMPLE_MIN;
      r.sat = 1'b1;
    end else begin
      r.sample = sample_t'(acc);
    end
    // clipped value goes into the feedback line
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = r.sample;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d sat %0b", sample_out, saturated));
      end else begin
        want = pending_results.pop_front();
        if (want.sat)
          clipped_seen++;
        if (sample_out !== want.sample)
          report_mismatch($sformatf("sample_out %0d, predicted %0d", sample_out, want.sample));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated %0b, predicted %0b", saturated, want.sat));
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_pct = 0;
        recv_pct = 0;
      end
      IDLE_SENDER: begin
        send_pct = 66;
        recv_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_pct = 0;
        recv_pct = 66;
      end
      default: begin
        send_pct = 29;
        recv_pct = 29;
      end
    endcase
  endtask

  task automatic send_sample(input sample_t x);
    int gap;
    gap = 0;
    while (send_pct > 0 && gap < GAP_CAP && $urandom_range(99) < send_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(filter_step(x));
    samples_sent++;
  endtask

  // hold off new requests until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input cfg_idx_t idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEFS)
      coef_model[idx] = val;
    coef_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(2097152)) - 1048576);
      2: begin
        case ($urandom_range(4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          3: return sample_t'(1);
          default: return sample_t'(-1);
        endcase
      end
      default: return sample_t'(int'($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      set_idling(idle_mode_e'((random_count / 16) % 4));
      send_sample(rand_sample());
      random_count++;
    end
  endtask

  task automatic test_reset_coefficients();
    sample_t seq [] = '{'0, ONE, '0, '0, '0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
                        sample_t'(-1), 32'sh55555555, 32'shAAAAAAAA, '0};
    set_idling(IDLE_NONE);
    foreach (seq[i])
      send_sample(seq[i]);
    drain();
  endtask

  task automatic test_saturation();
    // pure gain of almost 128 on the current input
    write_coef(REG_B0, COEF_MAX);
    write_coef(REG_B1, '0);
    write_coef(REG_B2, '0);
    write_coef(REG_B3, '0);
    write_coef(REG_A1, '0);
    write_coef(REG_A2, '0);
    write_coef(REG_A3, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(ONE);
    drain();
    write_coef(REG_B0, COEF_MIN);
    write_coef(REG_A1, COEF_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    drain();
    // index past the last coefficient must leave every coefficient alone
    write_coef(IDX_PAST_LAST, '0);
    send_sample('0);
    drain();
    write_coef(REG_A1, COEF_MIN);
    write_coef(REG_B1, COEF_MIN);
    write_coef(REG_B2, COEF_MAX);
    write_coef(REG_B3, COEF_MIN);
    write_coef(REG_A2, COEF_MIN);
    write_coef(REG_A3, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(sample_t'(-1));
    send_sample(SAMPLE_MIN);
    send_sample('0);
    drain();
  endtask

  task automatic test_fir_random(input int n);
    write_coef(REG_A1, '0);
    write_coef(REG_A2, '0);
    write_coef(REG_A3, '0);
    write_coef(REG_B0, coef_t'($urandom));
    write_coef(REG_B1, coef_t'($urandom));
    write_coef(REG_B2, coef_t'($urandom));
    write_coef(REG_B3, coef_t'($urandom));
    run_random(n);
    drain();
  endtask

  task automatic test_loop_filter_random(input int n, input int burst);
    for (int r = 0; r < NUM_COEFS; r++)
      write_coef(cfg_idx_t'(r), COEF_RESET[r]);
    for (int done = 0; done < n; done += burst) begin
      run_random(burst);
      drain();
    end
  endtask

  task automatic test_random_coefficients(input int n);
    // small coefficients keep the loop stable, full range mostly clips
    for (int r = 0; r < NUM_COEFS; r++)
      write_coef(cfg_idx_t'(r), coef_t'(int'($urandom_range(32768)) - 16384));
    run_random(n);
    drain();
    for (int r = 0; r < NUM_COEFS; r++)
      write_coef(cfg_idx_t'(r), coef_t'($urandom));
    write_coef(IDX_PAST_LAST, coef_t'($urandom));
    run_random(n);
    drain();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample_in <= '0;
    out_ready <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    coef_model = COEF_RESET;
    for (int t = 0; t < TAPS; t++) begin
      x_hist[t] = '0;
      y_hist[t] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_coefficients();
    test_saturation();
    test_fir_random(100);
    test_loop_filter_random(150, 50);
    test_random_coefficients(60);

    drain();
    repeat (5) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d samples and %0d results (%0d clipped) over %0d coefficient writes",
             samples_sent, results_seen, clipped_seen, coef_writes);
    $display("coefficient sets: reset loop filter, extremes, random fir, random feedback");
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
